[src/rpfe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpfe_pkg
// Types, constants and the BT.601 helper for the RGB pixel format encoder.
// ----------------------------------------------------------------------------
package rpfe_pkg;

    typedef enum logic [1:0] {
        FMT_RGB888 = 2'd0,
        FMT_BGR888 = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_YUYV   = 2'd3
    } pixel_fmt_t;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] count_t;

    localparam count_t CNT_NONE   = 3'd0;
    localparam count_t CNT_RGB565 = 3'd2;
    localparam count_t CNT_RGB888 = 3'd3;
    localparam count_t CNT_YUYV   = 3'd4;

    // BT.601 coefficients
    localparam logic signed [8:0] Y_KR = 9'sd66;
    localparam logic signed [8:0] Y_KG = 9'sd129;
    localparam logic signed [8:0] Y_KB = 9'sd25;
    localparam logic signed [8:0] U_KR = -9'sd38;
    localparam logic signed [8:0] U_KG = -9'sd74;
    localparam logic signed [8:0] U_KB = 9'sd112;
    localparam logic signed [8:0] V_KR = 9'sd112;
    localparam logic signed [8:0] V_KG = -9'sd94;
    localparam logic signed [8:0] V_KB = -9'sd18;
    localparam byte_t LUMA_OFS   = 8'd16;
    localparam byte_t CHROMA_OFS = 8'd128;

    // Rounding constant 128 plus a 32768 bias that keeps the sum positive,
    // so the arithmetic shift becomes a plain bit-select.
    localparam logic signed [18:0] SUM_BIAS = 19'sd32896;
    localparam logic signed [11:0] BIAS_Q   = 12'sd128;

    function automatic byte_t bt601(
        input logic signed [8:0] kr,
        input logic signed [8:0] kg,
        input logic signed [8:0] kb,
        input byte_t             ofs,
        input byte_t             r,
        input byte_t             g,
        input byte_t             b
    );
        logic signed [18:0] sum;
        logic signed [11:0] t;
        byte_t              res;
        sum = kr * $signed({1'b0, r}) + kg * $signed({1'b0, g})
            + kb * $signed({1'b0, b}) + SUM_BIAS;
        t   = $signed({1'b0, sum[18:8]}) - BIAS_Q + $signed({4'b0000, ofs});
        if (t < 12'sd0)
            res = 8'd0;
        else if (t > 12'sd255)
            res = 8'd255;
        else
            res = t[7:0];
        return res;
    endfunction

endpackage
`default_nettype wire

[src/rgb_pixel_format_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_pixel_format_encoder
// Converts an RGB888 pixel stream to RGB888, BGR888, RGB565 or YUYV bytes.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while the output is not stalled. A pixel lands
// in an input register; the format logic and the BT.601 matrix sit between
// that register and the result register. A stalled result holds the input
// register and so stalls the input. RGB888/BGR888/RGB565 give one result per
// pixel. YUYV gives one 4-byte result per pixel pair; a lone pixel at a row
// or frame end gives a zero-byte result that only carries the markers. Writing
// the format with cfg_we drops a held YUYV pixel; write it only while the block
// is idle.
module rgb_pixel_format_encoder (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire [1:0]           cfg_wdata,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire [7:0]           red,
    input  wire [7:0]           green,
    input  wire [7:0]           blue,
    input  wire                 row_end,
    input  wire                 frame_end,
    output logic                out_valid,
    input  wire                 out_stall,
    output rpfe_pkg::byte_t     out_byte0,
    output rpfe_pkg::byte_t     out_byte1,
    output rpfe_pkg::byte_t     out_byte2,
    output rpfe_pkg::byte_t     out_byte3,
    output rpfe_pkg::count_t    byte_count,
    output logic                row_last,
    output logic                frame_last
);
    import rpfe_pkg::*;

    pixel_fmt_t fmt_reg;

    // input register
    logic  s1_valid_reg, s1_valid_next;
    byte_t s1_red_reg, s1_green_reg, s1_blue_reg;
    logic  s1_row_reg, s1_frame_reg;

    // pair state
    logic  pend_reg, pend_next;
    byte_t held_y_reg, held_u_reg, held_v_reg;

    // result register
    logic   out_valid_reg, out_valid_next;
    byte_t  b0_reg, b1_reg, b2_reg, b3_reg;
    count_t cnt_reg;
    logic   row_reg, frame_reg;

    byte_t  y_c, u_c, v_c;
    byte_t  b0_c, b1_c, b2_c, b3_c;
    count_t cnt_c;
    logic   has_result, hold_pixel;
    logic   out_ready, s1_fire, accept;

    assign y_c = bt601(Y_KR, Y_KG, Y_KB, LUMA_OFS,   s1_red_reg, s1_green_reg, s1_blue_reg);
    assign u_c = bt601(U_KR, U_KG, U_KB, CHROMA_OFS, s1_red_reg, s1_green_reg, s1_blue_reg);
    assign v_c = bt601(V_KR, V_KG, V_KB, CHROMA_OFS, s1_red_reg, s1_green_reg, s1_blue_reg);

    always_comb
    begin
        b0_c       = '0;
        b1_c       = '0;
        b2_c       = '0;
        b3_c       = '0;
        cnt_c      = CNT_NONE;
        has_result = 1'b1;
        hold_pixel = 1'b0;
        unique case (fmt_reg)
            FMT_RGB888:
            begin
                b0_c  = s1_red_reg;
                b1_c  = s1_green_reg;
                b2_c  = s1_blue_reg;
                cnt_c = CNT_RGB888;
            end
            FMT_BGR888:
            begin
                b0_c  = s1_blue_reg;
                b1_c  = s1_green_reg;
                b2_c  = s1_red_reg;
                cnt_c = CNT_RGB888;
            end
            FMT_RGB565:
            begin
                b0_c  = {s1_red_reg[7:3], s1_green_reg[7:5]};
                b1_c  = {s1_green_reg[4:2], s1_blue_reg[7:3]};
                cnt_c = CNT_RGB565;
            end
            FMT_YUYV:
            begin
                priority if (pend_reg)
                begin
                    b0_c  = held_y_reg;
                    b1_c  = 8'(({1'b0, held_u_reg} + {1'b0, u_c}) >> 1);
                    b2_c  = y_c;
                    b3_c  = 8'(({1'b0, held_v_reg} + {1'b0, v_c}) >> 1);
                    cnt_c = CNT_YUYV;
                end
                else if (s1_row_reg || s1_frame_reg)
                begin
                    // odd trailing pixel: dropped, markers still go out
                    cnt_c = CNT_NONE;
                end
                else
                begin
                    has_result = 1'b0;
                    hold_pixel = 1'b1;
                end
            end
        endcase
    end

    // handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && (!has_result || out_ready);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && has_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (cfg_we)
            pend_next = 1'b0;
        else if (s1_fire)
            pend_next = hold_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_RGB888;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fmt_reg <= pixel_fmt_t'(cfg_wdata);
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s1_row_reg   <= row_end;
            s1_frame_reg <= frame_end;
        end
        if (s1_fire && hold_pixel)
        begin
            held_y_reg <= y_c;
            held_u_reg <= u_c;
            held_v_reg <= v_c;
        end
        if (s1_fire && has_result)
        begin
            b0_reg    <= b0_c;
            b1_reg    <= b1_c;
            b2_reg    <= b2_c;
            b3_reg    <= b3_c;
            cnt_reg   <= cnt_c;
            row_reg   <= s1_row_reg;
            frame_reg <= s1_frame_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte0  = b0_reg;
    assign out_byte1  = b1_reg;
    assign out_byte2  = b2_reg;
    assign out_byte3  = b3_reg;
    assign byte_count = cnt_reg;
    assign row_last   = row_reg;
    assign frame_last = frame_reg;

endmodule
`default_nettype wire

[src/rpfe_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpfe_checker
// Port-level checks for the RGB pixel format encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rpfe_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_stall,
    input wire                 out_valid,
    input wire                 out_stall,
    input rpfe_pkg::byte_t     out_byte0,
    input rpfe_pkg::byte_t     out_byte1,
    input rpfe_pkg::byte_t     out_byte2,
    input rpfe_pkg::byte_t     out_byte3,
    input rpfe_pkg::count_t    byte_count,
    input wire                 row_last,
    input wire                 frame_last
);
    import rpfe_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte0) && $stable(out_byte1)
            && $stable(out_byte2) && $stable(out_byte3) && $stable(byte_count)
            && $stable(row_last) && $stable(frame_last))
        else $error("result changed while stalled");

    // input backpressure only comes from a stalled output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // legal byte counts; an empty request must carry a marker
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == CNT_NONE && (row_last || frame_last))
            || byte_count == CNT_RGB565 || byte_count == CNT_RGB888
            || byte_count == CNT_YUYV)
        else $error("illegal byte count");

    // bytes past the count are zero
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == CNT_YUYV || out_byte3 == 8'd0)
            && (byte_count >= CNT_RGB888 || out_byte2 == 8'd0)
            && (byte_count >= CNT_RGB565 || (out_byte1 == 8'd0 && out_byte0 == 8'd0)))
        else $error("unused output byte not zero");

endmodule

bind rgb_pixel_format_encoder rpfe_checker u_rpfe_checker (.*);
`default_nettype wire

[dv/tb_rgb_pixel_format_encoder.sv]
// ----------------------------------------------------------------------------
// tb_rgb_pixel_format_encoder
// Self-checking bench for the RGB pixel format encoder. A directed table covers
// every output format and the YUYV pairing corner cases. Random rows follow in
// phases of random format, with idle gaps on the input and stalls on the output.
// Every request is predicted in the bench, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_rgb_pixel_format_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import rpfe_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int PIPE_LATENCY = 4;        // two-stage pipe plus margin
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        byte_t  b0;
        byte_t  b1;
        byte_t  b2;
        byte_t  b3;
        count_t cnt;
        logic   row_last;
        logic   frame_last;
    } encoded_t;

    typedef struct packed {
        pixel_fmt_t fmt;
        logic       rewrite;    // write the format again even if unchanged
        byte_t      r;
        byte_t      g;
        byte_t      b;
        logic       re;
        logic       fe;
        logic       typed;      // use the result below instead of the predictor
        encoded_t   want;
    } pixel_vec_t;

    localparam encoded_t NO_RESULT = '0;

    localparam pixel_vec_t DIRECTED [0:20] = '{
        // RGB888 straight after reset
        '{FMT_RGB888, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, CNT_RGB888, 1'b0, 1'b0}},
        '{FMT_RGB888, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1,
          '{8'hFF, 8'hFF, 8'hFF, 8'h00, CNT_RGB888, 1'b1, 1'b1}},
        '{FMT_RGB888, 1'b0, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{FMT_BGR888, 1'b0, 8'h12, 8'h34, 8'h56, 1'b1, 1'b0, 1'b1,
          '{8'h56, 8'h34, 8'h12, 8'h00, CNT_RGB888, 1'b1, 1'b0}},
        '{FMT_RGB565, 1'b0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'hF8, 8'h00, 8'h00, 8'h00, CNT_RGB565, 1'b0, 1'b0}},
        '{FMT_RGB565, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'h07, 8'hE0, 8'h00, 8'h00, CNT_RGB565, 1'b0, 1'b0}},
        '{FMT_RGB565, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1,
          '{8'h00, 8'h1F, 8'h00, 8'h00, CNT_RGB565, 1'b0, 1'b1}},
        // YUYV white and black pairs
        '{FMT_YUYV, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{FMT_YUYV, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1,
          '{8'hEB, 8'h80, 8'hEB, 8'h80, CNT_YUYV, 1'b0, 1'b0}},
        '{FMT_YUYV, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{FMT_YUYV, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1,
          '{8'h10, 8'h80, 8'h10, 8'h80, CNT_YUYV, 1'b1, 1'b1}},
        // saturated primaries: negative sums before the shift
        '{FMT_YUYV, 1'b0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{FMT_YUYV, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
        // lone pixel at row end is dropped, markers survive
        '{FMT_YUYV, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, CNT_NONE, 1'b1, 1'b0}},
        // frame end alone also drops a lone pixel, marker survives
        '{FMT_YUYV, 1'b0, 8'h80, 8'h80, 8'h80, 1'b0, 1'b1, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, CNT_NONE, 1'b0, 1'b1}},
        // held pixel, then a format change drops it
        '{FMT_YUYV, 1'b0, 8'hA5, 8'h5A, 8'hC3, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{FMT_RGB565, 1'b0, 8'hA5, 8'h5A, 8'hC3, 1'b0, 1'b0, 1'b0, NO_RESULT},
        // held pixel, then a rewrite of the same format drops it
        '{FMT_YUYV, 1'b0, 8'h01, 8'h02, 8'h03, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{FMT_YUYV, 1'b1, 8'hFE, 8'h80, 8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{FMT_YUYV, 1'b0, 8'h40, 8'hC0, 8'h20, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{FMT_RGB888, 1'b0, 8'hFF, 8'h00, 8'h80, 1'b1, 1'b1, 1'b0, NO_RESULT}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       in_valid;
    logic       in_stall;
    byte_t      red;
    byte_t      green;
    byte_t      blue;
    logic       row_end;
    logic       frame_end;
    logic       out_valid;
    logic       out_stall = 1'b0;
    byte_t      out_byte0;
    byte_t      out_byte1;
    byte_t      out_byte2;
    byte_t      out_byte3;
    count_t     byte_count;
    logic       row_last;
    logic       frame_last;

    // predictor state
    pixel_fmt_t model_fmt;
    logic       yuyv_held;
    byte_t      held_y;
    byte_t      held_u;
    byte_t      held_v;

    encoded_t   encoded_q[$];
    int         err_count = 0;
    int         result_count = 0;
    int         cycle_count = 0;
    int         gap_pct;
    int         stall_pct;
    int         stall_left = 0;

    rgb_pixel_format_encoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte0  (out_byte0),
        .out_byte1  (out_byte1),
        .out_byte2  (out_byte2),
        .out_byte3  (out_byte3),
        .byte_count (byte_count),
        .row_last   (row_last),
        .frame_last (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // BT.601 with arithmetic shift and clamp to a byte
    function automatic byte_t bt601_component(input int kr, input int kg, input int kb,
                                              input int ofs, input byte_t r,
                                              input byte_t g, input byte_t b);
        int acc;
        acc = kr * int'(r) + kg * int'(g) + kb * int'(b) + 128;
        acc = (acc >>> 8) + ofs;
        if (acc < 0)
            acc = 0;
        else if (acc > 255)
            acc = 255;
        return byte_t'(acc);
    endfunction

    // Returns 1 when the pixel produces a result; updates the pairing state.
    function automatic bit encode_pixel(input byte_t r, input byte_t g, input byte_t b,
                                        input logic re, input logic fe,
                                        output encoded_t res);
        byte_t y;
        byte_t u;
        byte_t v;
        res            = NO_RESULT;
        res.row_last   = re;
        res.frame_last = fe;
        case (model_fmt)
            FMT_RGB888:
            begin
                res.b0    = r;
                res.b1    = g;
                res.b2    = b;
                res.cnt   = CNT_RGB888;
                yuyv_held = 1'b0;
            end
            FMT_BGR888:
            begin
                res.b0    = b;
                res.b1    = g;
                res.b2    = r;
                res.cnt   = CNT_RGB888;
                yuyv_held = 1'b0;
            end
            FMT_RGB565:
            begin
                res.b0    = {r[7:3], g[7:5]};
                res.b1    = {g[4:2], b[7:3]};
                res.cnt   = CNT_RGB565;
                yuyv_held = 1'b0;
            end
            default:
            begin
                y = bt601_component(66, 129, 25, 16, r, g, b);
                u = bt601_component(-38, -74, 112, 128, r, g, b);
                v = bt601_component(112, -94, -18, 128, r, g, b);
                if (yuyv_held)
                begin
                    res.b0    = held_y;
                    res.b1    = byte_t'((int'(held_u) + int'(u)) >> 1);
                    res.b2    = y;
                    res.b3    = byte_t'((int'(held_v) + int'(v)) >> 1);
                    res.cnt   = CNT_YUYV;
                    yuyv_held = 1'b0;
                end
                else if (re || fe)
                begin
                    res.cnt = CNT_NONE;
                end
                else
                begin
                    held_y    = y;
                    held_u    = u;
                    held_v    = v;
                    yuyv_held = 1'b1;
                    return 1'b0;
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(1, 3);
        else if (p < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic byte_t rand_component();
        int p;
        p = $urandom_range(0, 7);
        if (p == 0)
            return 8'h00;
        else if (p == 1)
            return 8'hFF;
        return byte_t'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("ERROR t=%0t result %0d: %s", $time, result_count, msg);
        err_count++;
    endtask

    // four-state compare so that unknown outputs are caught
    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_result();
        encoded_t want;
        if (encoded_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result, byte_count %0d", byte_count));
        end
        else
        begin
            want = encoded_q.pop_front();
            compare_field("out_byte0", 32'(out_byte0), 32'(want.b0));
            compare_field("out_byte1", 32'(out_byte1), 32'(want.b1));
            compare_field("out_byte2", 32'(out_byte2), 32'(want.b2));
            compare_field("out_byte3", 32'(out_byte3), 32'(want.b3));
            compare_field("byte_count", 32'(byte_count), 32'(want.cnt));
            compare_field("row_last", 32'(row_last), 32'(want.row_last));
            compare_field("frame_last", 32'(frame_last), 32'(want.frame_last));
        end
        result_count++;
    endtask

    // output side: check accepted results, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = idle_len() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rgb_pixel_format_encoder test failed");
            $finish;
        end
    end

    // Drive one request and hold it until accepted; leaves in_valid high
    // unless a gap follows.
    task automatic send_pixel(input byte_t r, input byte_t g, input byte_t b,
                              input logic re, input logic fe,
                              input logic typed, input encoded_t typed_res);
        encoded_t res;
        bit       has_res;
        int       gap;
        in_valid  <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        row_end   <= re;
        frame_end <= fe;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has_res = encode_pixel(r, g, b, re, fe, res);
        if (typed)
            encoded_q.push_back(typed_res);
        else if (has_res)
            encoded_q.push_back(res);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            gap = idle_len();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (encoded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_format(input pixel_fmt_t fmt);
        wait_drained();
        // a held YUYV pixel gives no result, so let the pipe settle
        repeat (PIPE_LATENCY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_fmt = fmt;
        yuyv_held = 1'b0;
    endtask

    initial
    begin
        int         sent;
        int         rows;
        int         len;
        int         p;
        pixel_fmt_t fmt;
        logic       re;
        logic       fe;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = FMT_RGB888;
        in_valid     = 1'b0;
        red          = '0;
        green        = '0;
        blue         = '0;
        row_end      = 1'b0;
        frame_end    = 1'b0;
        model_fmt    = FMT_RGB888;
        yuyv_held    = 1'b0;
        held_y       = '0;
        held_u       = '0;
        held_v       = '0;
        gap_pct      = 20;
        stall_pct    = 20;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].fmt != model_fmt || DIRECTED[i].rewrite)
                write_format(DIRECTED[i].fmt);
            send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].re,
                       DIRECTED[i].fe, DIRECTED[i].typed, DIRECTED[i].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            p = $urandom_range(0, 99);
            fmt = (p < 45) ? FMT_YUYV : pixel_fmt_t'($urandom_range(0, 2));
            p = $urandom_range(0, 2);
            gap_pct = (p == 0) ? 0 : (p == 1) ? 10 : 35;
            p = $urandom_range(0, 2);
            stall_pct = (p == 0) ? 0 : (p == 1) ? 10 : 35;
            write_format(fmt);
            rows = $urandom_range(2, 10);
            repeat (rows)
            begin
                len = $urandom_range(1, 24);
                // YUYV rows are mostly even so pairs close cleanly
                if (fmt == FMT_YUYV && $urandom_range(0, 3) != 0)
                    len += len % 2;
                for (int k = 0; k < len; k++)
                begin
                    re = (k == len - 1) || ($urandom_range(0, 39) == 0);
                    fe = ((k == len - 1) && ($urandom_range(0, 3) == 0))
                         || ($urandom_range(0, 59) == 0);
                    send_pixel(rand_component(), rand_component(), rand_component(),
                               re, fe, 1'b0, NO_RESULT);
                    sent++;
                end
                if ($urandom_range(0, 15) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (PIPE_LATENCY * 2) @(posedge clk);
        if (err_count == 0)
            $display("rgb_pixel_format_encoder test passed");
        else
            $display("rgb_pixel_format_encoder test failed");
        $finish;
    end

endmodule
